@@ hw/rtl/pcc_pkg.sv @@
`default_nettype none

package pcc_pkg;

   localparam int ITERATIONS    = 16;
   localparam int COORD_WIDTH   = 16;
   localparam int FIELD_W       = 16;
   localparam int FRAC_EXTRA    = 14;
   localparam int GAIN_Q16      = 39797;
   localparam int GAIN_SHIFT    = 16;
   localparam int GAIN_W        = 17;
   localparam int DEG_SHIFT     = 9;
   localparam int HALF_TURN     = 23040;
   localparam int QUARTER_TURN  = 11520;
   localparam int FULL_TURN     = 46080;
   localparam int MAX_STAGES    = 24;
   localparam int ATAN_IDX_W    = 5;

   // Internal coordinates keep FRAC_EXTRA more fraction bits, plus room for
   // the CORDIC gain and a sign.
   localparam int DATA_W        = FIELD_W + FRAC_EXTRA + 3;
   localparam int ANGLE_W       = 27;
   localparam int STAGE_W       = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
   localparam int PROD_W        = DATA_W + GAIN_W;
   localparam int DESCALE_SHIFT = GAIN_SHIFT + FRAC_EXTRA;
   localparam int RES_W         = PROD_W - DESCALE_SHIFT;

   typedef enum logic {
      OP_TO_CART  = 1'b0,
      OP_TO_POLAR = 1'b1
   } pcc_opcode_type;

   typedef struct packed {
      pcc_opcode_type            mode;
      logic                      flip;
      logic                      origin;
      logic signed [DATA_W-1:0]  x;
      logic signed [DATA_W-1:0]  y;
      logic signed [ANGLE_W-1:0] z;
   } pcc_work_type;

   // atan(2^-i) in units of 2^-16 degree.
   localparam logic [ANGLE_W-1:0] ATAN_TABLE [MAX_STAGES] = '{
      27'd2949120, 27'd1740967, 27'd919879, 27'd466945,
      27'd234379,  27'd117304,  27'd58666,  27'd29335,
      27'd14668,   27'd7334,    27'd3667,   27'd1833,
      27'd917,     27'd458,     27'd229,    27'd115,
      27'd57,      27'd29,      27'd14,     27'd7,
      27'd4,       27'd2,       27'd1,      27'd0
   };

   function automatic logic signed [ANGLE_W-1:0] atan_lookup(input logic [STAGE_W-1:0] idx);
      return $signed(ATAN_TABLE[ATAN_IDX_W'(idx)]);
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pcc_if.sv @@
`default_nettype none

interface pcc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 opcode;
   logic signed [pcc_pkg::FIELD_W-1:0]   x_in;
   logic signed [pcc_pkg::FIELD_W-1:0]   y_in;
   logic        [pcc_pkg::FIELD_W-1:0]   radius_in;
   logic signed [pcc_pkg::FIELD_W-1:0]   angle_in;

   modport source (output valid, opcode, x_in, y_in, radius_in, angle_in, input ready);
   modport sink   (input valid, opcode, x_in, y_in, radius_in, angle_in, output ready);
endinterface

interface pcc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pcc_pkg::FIELD_W-1:0]   x_out;
   logic signed [pcc_pkg::FIELD_W-1:0]   y_out;
   logic        [pcc_pkg::FIELD_W-1:0]   radius_out;
   logic signed [pcc_pkg::FIELD_W-1:0]   angle_out;
   logic                                 saturated;

   modport source (output valid, x_out, y_out, radius_out, angle_out, saturated, input ready);
   modport sink   (input valid, x_out, y_out, radius_out, angle_out, saturated, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pcc_prep.sv @@
`default_nettype none

module pcc_prep (
   input  logic                 clock,
   input  logic                 reset,
   pcc_req_if.sink              req_bus,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output pcc_pkg::pcc_work_type dn_data
);
   import pcc_pkg::*;

   localparam logic signed [17:0] HALF_A    = 18'(HALF_TURN);
   localparam logic signed [17:0] QUARTER_A = 18'(QUARTER_TURN);
   localparam logic signed [17:0] FULL_A    = 18'(FULL_TURN);
   localparam logic signed [ANGLE_W-1:0] HALF_Z = ANGLE_W'(HALF_TURN) <<< DEG_SHIFT;

   logic                      valid_ff;
   pcc_work_type              data_ff;
   pcc_work_type              data_in;
   logic                      load;

   logic signed [17:0]        ang_raw;
   logic signed [17:0]        ang_wrap;
   logic signed [17:0]        ang_fold;
   logic                      flip;
   logic signed [FIELD_W:0]   xs;
   logic signed [FIELD_W:0]   ys;
   logic signed [FIELD_W:0]   xv;
   logic signed [FIELD_W:0]   yv;
   logic                      x_neg;

   assign req_bus.ready = !valid_ff || dn_ready;
   assign load          = req_bus.valid && req_bus.ready;
   assign dn_valid      = valid_ff;
   assign dn_data       = data_ff;

   always_comb begin
      ang_raw = 18'(req_bus.angle_in);
      if (ang_raw > HALF_A) begin
         ang_wrap = ang_raw - FULL_A;
      end else if (ang_raw < -HALF_A) begin
         ang_wrap = ang_raw + FULL_A;
      end else begin
         ang_wrap = ang_raw;
      end
      // Beyond a quarter turn either way, fold the angle by half a turn and negate the result.
      flip = 1'b1;
      if (ang_wrap > QUARTER_A) begin
         ang_fold = ang_wrap - HALF_A;
      end else if (ang_wrap < -QUARTER_A) begin
         ang_fold = ang_wrap + HALF_A;
      end else begin
         ang_fold = ang_wrap;
         flip     = 1'b0;
      end

      xs    = (FIELD_W + 1)'(req_bus.x_in);
      ys    = (FIELD_W + 1)'(req_bus.y_in);
      x_neg = xs < 0;
      xv    = x_neg ? -xs : xs;
      yv    = x_neg ? -ys : ys;

      data_in = '0;
      if (req_bus.opcode == OP_TO_POLAR) begin
         data_in.mode   = OP_TO_POLAR;
         data_in.origin = (xs == 0) && (ys == 0);
         data_in.x      = DATA_W'(xv) <<< FRAC_EXTRA;
         data_in.y      = DATA_W'(yv) <<< FRAC_EXTRA;
         if (x_neg) begin
            data_in.z = (ys >= 0) ? HALF_Z : -HALF_Z;
         end
      end else begin
         data_in.mode = OP_TO_CART;
         data_in.flip = flip;
         data_in.x    = $signed(DATA_W'(req_bus.radius_in) << FRAC_EXTRA);
         data_in.z    = ANGLE_W'(ang_fold) <<< DEG_SHIFT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/pcc_cell.sv @@
`default_nettype none

module pcc_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pcc_pkg::STAGE_W-1:0]   stage_idx,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  pcc_pkg::pcc_work_type         up_data,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output pcc_pkg::pcc_work_type         dn_data
);
   import pcc_pkg::*;

   logic                      valid_ff;
   pcc_work_type              data_ff;
   pcc_work_type              data_in;
   logic                      load;
   logic                      dir_neg;
   logic signed [DATA_W-1:0]  dx;
   logic signed [DATA_W-1:0]  dy;
   logic signed [ANGLE_W-1:0] da;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_comb begin
      dx = up_data.y >>> stage_idx;
      dy = up_data.x >>> stage_idx;
      da = atan_lookup(stage_idx);
      // Rotation follows the residual angle, vectoring drives y toward zero.
      if (up_data.mode == OP_TO_CART) begin
         dir_neg = up_data.z >= 0;
      end else begin
         dir_neg = up_data.y < 0;
      end
      data_in = up_data;
      if (dir_neg) begin
         data_in.x = up_data.x - dx;
         data_in.y = up_data.y + dy;
         data_in.z = up_data.z - da;
      end else begin
         data_in.x = up_data.x + dx;
         data_in.y = up_data.y - dy;
         data_in.z = up_data.z + da;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/pcc_post.sv @@
`default_nettype none

module pcc_post (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  pcc_pkg::pcc_work_type up_data,
   pcc_rsp_if.source             rsp_bus
);
   import pcc_pkg::*;

   localparam int SAT_W = (RES_W + 1 > COORD_WIDTH + 1) ? RES_W + 1 : COORD_WIDTH + 1;
   localparam logic signed [GAIN_W-1:0]  GAIN_S  = GAIN_W'(GAIN_Q16);
   localparam logic signed [PROD_W-1:0]  ROUND_P = PROD_W'(64'd1 << (DESCALE_SHIFT - 1));
   localparam logic signed [SAT_W-1:0]   SAT_HI  = SAT_W'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
   localparam logic signed [SAT_W-1:0]   SAT_LO  = -SAT_HI - SAT_W'(1);
   localparam logic signed [RES_W-1:0]   RAD_MAX = RES_W'(65535);
   localparam logic signed [ANGLE_W-1:0] Z_ROUND = ANGLE_W'(1) <<< (DEG_SHIFT - 1);
   localparam logic signed [ANGLE_W-1:0] HALF_Q  = ANGLE_W'(HALF_TURN);
   localparam logic signed [ANGLE_W-1:0] FULL_Q  = ANGLE_W'(FULL_TURN);

   // Product stage.
   logic                      a_valid_ff;
   logic                      a_ready;
   pcc_opcode_type            a_mode_ff;
   logic                      a_flip_ff;
   logic                      a_origin_ff;
   logic signed [PROD_W-1:0]  a_px_ff;
   logic signed [PROD_W-1:0]  a_py_ff;
   logic signed [ANGLE_W-1:0] a_z_ff;
   logic signed [PROD_W-1:0]  a_px_in;
   logic signed [PROD_W-1:0]  a_py_in;
   logic                      a_load;

   // Output register.
   logic                      b_valid_ff;
   logic signed [FIELD_W-1:0] b_x_ff;
   logic signed [FIELD_W-1:0] b_y_ff;
   logic        [FIELD_W-1:0] b_radius_ff;
   logic signed [FIELD_W-1:0] b_angle_ff;
   logic                      b_sat_ff;
   logic signed [FIELD_W-1:0] b_x_in;
   logic signed [FIELD_W-1:0] b_y_in;
   logic        [FIELD_W-1:0] b_radius_in;
   logic signed [FIELD_W-1:0] b_angle_in;
   logic                      b_sat_in;
   logic                      b_load;

   logic signed [RES_W-1:0]   rx;
   logic signed [RES_W-1:0]   ry;
   logic signed [SAT_W-1:0]   vx;
   logic signed [SAT_W-1:0]   vy;
   logic signed [SAT_W-1:0]   sx;
   logic signed [SAT_W-1:0]   sy;
   logic signed [ANGLE_W-1:0] zr;
   logic signed [ANGLE_W-1:0] zw;

   assign a_ready  = !b_valid_ff || rsp_bus.ready;
   assign up_ready = !a_valid_ff || a_ready;
   assign a_load   = up_valid && up_ready;
   assign b_load   = a_valid_ff && a_ready;

   assign a_px_in = up_data.x * GAIN_S;
   assign a_py_in = up_data.y * GAIN_S;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (up_ready) begin
         a_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_mode_ff   <= up_data.mode;
         a_flip_ff   <= up_data.flip;
         a_origin_ff <= up_data.origin;
         a_px_ff     <= a_px_in;
         a_py_ff     <= a_py_in;
         a_z_ff      <= up_data.z;
      end
   end

   always_comb begin
      rx = RES_W'((a_px_ff + ROUND_P) >>> DESCALE_SHIFT);
      ry = RES_W'((a_py_ff + ROUND_P) >>> DESCALE_SHIFT);
      vx = a_flip_ff ? -SAT_W'(rx) : SAT_W'(rx);
      vy = a_flip_ff ? -SAT_W'(ry) : SAT_W'(ry);
      b_sat_in = 1'b0;
      if (vx > SAT_HI) begin
         sx = SAT_HI;
         b_sat_in = 1'b1;
      end else if (vx < SAT_LO) begin
         sx = SAT_LO;
         b_sat_in = 1'b1;
      end else begin
         sx = vx;
      end
      if (vy > SAT_HI) begin
         sy = SAT_HI;
         b_sat_in = 1'b1;
      end else if (vy < SAT_LO) begin
         sy = SAT_LO;
         b_sat_in = 1'b1;
      end else begin
         sy = vy;
      end

      zr = (a_z_ff + Z_ROUND) >>> DEG_SHIFT;
      if (zr > HALF_Q) begin
         zw = zr - FULL_Q;
      end else if (zr < -HALF_Q) begin
         zw = zr + FULL_Q;
      end else begin
         zw = zr;
      end

      b_x_in      = '0;
      b_y_in      = '0;
      b_radius_in = '0;
      b_angle_in  = '0;
      if (a_mode_ff == OP_TO_CART) begin
         b_x_in = sx[FIELD_W-1:0];
         b_y_in = sy[FIELD_W-1:0];
      end else begin
         b_sat_in = 1'b0;
         if (!a_origin_ff) begin
            if (rx < 0) begin
               b_radius_in = '0;
            end else if (rx > RAD_MAX) begin
               b_radius_in = '1;
            end else begin
               b_radius_in = rx[FIELD_W-1:0];
            end
            b_angle_in = zw[FIELD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (a_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         b_x_ff      <= b_x_in;
         b_y_ff      <= b_y_in;
         b_radius_ff <= b_radius_in;
         b_angle_ff  <= b_angle_in;
         b_sat_ff    <= b_sat_in;
      end
   end

   assign rsp_bus.valid      = b_valid_ff;
   assign rsp_bus.x_out      = b_x_ff;
   assign rsp_bus.y_out      = b_y_ff;
   assign rsp_bus.radius_out = b_radius_ff;
   assign rsp_bus.angle_out  = b_angle_ff;
   assign rsp_bus.saturated  = b_sat_ff;

endmodule

`default_nettype wire

@@ hw/rtl/polar_cartesian_converter_top.sv @@
// CORDIC converter between polar and cartesian Q8.8 coordinates. Each req_ beat
// carries an opcode: polar to cartesian rotates (radius_in, 0) by angle_in, and
// cartesian to polar returns the radius and the four-quadrant angle, in 1/128
// degree. The datapath is a row of 16 micro-rotation cells between an input
// conditioning register and a two-register gain and rounding stage, so it takes
// one beat per clock while rsp_ is not stalled. Every register stage has its own
// valid and ready, so empty stages keep filling while a finished result waits on
// rsp_.
`default_nettype none

module polar_cartesian_converter_top (
   input  logic        clock,
   input  logic        reset,
   pcc_req_if.sink     req_bus,
   pcc_rsp_if.source   rsp_bus
);
   import pcc_pkg::*;

   logic         chain_valid [ITERATIONS+1];
   logic         chain_ready [ITERATIONS+1];
   pcc_work_type chain_data  [ITERATIONS+1];

   pcc_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .dn_valid (chain_valid[0]),
      .dn_ready (chain_ready[0]),
      .dn_data  (chain_data[0])
   );

   for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
      pcc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (STAGE_W'(k)),
         .up_valid  (chain_valid[k]),
         .up_ready  (chain_ready[k]),
         .up_data   (chain_data[k]),
         .dn_valid  (chain_valid[k+1]),
         .dn_ready  (chain_ready[k+1]),
         .dn_data   (chain_data[k+1])
      );
   end

   pcc_post u_post (
      .clock    (clock),
      .reset    (reset),
      .up_valid (chain_valid[ITERATIONS]),
      .up_ready (chain_ready[ITERATIONS]),
      .up_data  (chain_data[ITERATIONS]),
      .rsp_bus  (rsp_bus)
   );

`ifndef SYNTHESIS
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid)
      else $error("result valid right after reset");

   a_polar_fields_clear : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.saturated |-> rsp_bus.radius_out == '0 &&
         rsp_bus.angle_out == '0)
      else $error("cartesian result carries polar fields");

   a_cart_fields_clear : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.radius_out != '0 |-> rsp_bus.x_out == '0 &&
         rsp_bus.y_out == '0 && !rsp_bus.saturated)
      else $error("polar result carries cartesian fields");

   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> $signed(rsp_bus.angle_out) <= 16'sd23040 &&
         $signed(rsp_bus.angle_out) >= -16'sd23040)
      else $error("angle outside half a turn");
`endif

endmodule

`default_nettype wire
